FILE: hdl/cdad_pkg.sv
// shared types, constants and month-length function for the date-plus-days block
// used by cdad_ctrl, cdad_dp and calendar_date_add_days_core; no dependencies
`default_nettype none

package cdad_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned OFFS_W   = 16;
    localparam int unsigned ACC_W    = 17;
    localparam int unsigned CENT_W   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEARS_CENT = 14'd100;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;
    localparam logic [CENT_W-1:0]  YY_LAST    = 7'd99;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic walk_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/calendar_date_add_days_core.sv
// Adds a signed day count to a Gregorian date (years 1..9999) and returns the new date,
// saturating at the first or last representable day and raising the overflow flag when the
// year range is left. One item is in work at a time: after the accepting transfer the start
// year is split into century and year-in-century by repeated subtraction of 100, then the
// date walks one month per cycle until the day fits its month, then the result is handed to
// the output register once that register is free. The output register holds a finished
// result while the next item is taken.
// depends on cdad_pkg, cdad_ctrl and cdad_dp
`default_nettype none

module calendar_date_add_days_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[38:23], zero[39]
    input  wire  [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero[23]
    output logic [23:0] o_m_axis_tdata,
    // year_overflow[0]
    output logic [0:0]  o_m_axis_tuser
);

    cdad_pkg::t_dp_cmd cmd;
    cdad_pkg::t_dp_sts sts;

    logic [cdad_pkg::YEAR_W-1:0]  result_year;
    logic [cdad_pkg::MONTH_W-1:0] result_month;
    logic [cdad_pkg::DAY_W-1:0]   result_day;
    logic                         year_overflow;

    cdad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdad_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start_year    (i_s_axis_tdata[13:0]),
        .i_start_month   (i_s_axis_tdata[17:14]),
        .i_start_day     (i_s_axis_tdata[22:18]),
        .i_day_offset    ($signed(i_s_axis_tdata[38:23])),
        .i_m_tready      (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_result_year   (result_year),
        .o_result_month  (result_month),
        .o_result_day    (result_day),
        .o_year_overflow (year_overflow)
    );

    assign o_m_axis_tdata = {1'b0, result_day, result_month, result_year};
    assign o_m_axis_tuser = year_overflow;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register loaded while a result is still waiting");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (result_year >= cdad_pkg::YEAR_MIN
                             && result_year <= cdad_pkg::YEAR_MAX))
        else $error("result year outside 1..9999");

    a_sat_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && year_overflow) |->
            ((result_year == cdad_pkg::YEAR_MAX && result_month == cdad_pkg::MONTH_DEC
              && result_day == cdad_pkg::DAY_LAST)
             || (result_year == cdad_pkg::YEAR_MIN && result_month == cdad_pkg::MONTH_JAN
              && result_day == cdad_pkg::DAY_FIRST)))
        else $error("overflow flagged on a date that is not a range bound");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken again while an item is in work");

endmodule

`default_nettype wire

FILE: hdl/cdad_ctrl.sv
// controller state machine: load, century split, month walk, result hand-off
// depends on cdad_pkg
`default_nettype none

module cdad_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  cdad_pkg::t_dp_sts i_sts,
    output cdad_pkg::t_dp_cmd o_cmd
);

    cdad_pkg::t_state r_state;
    cdad_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cdad_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = cdad_pkg::ST_DIV;
            end
            cdad_pkg::ST_DIV: begin
                if (!i_sts.div_busy) n_state = cdad_pkg::ST_WALK;
            end
            cdad_pkg::ST_WALK: begin
                if (i_sts.walk_done) n_state = cdad_pkg::ST_OUT;
            end
            cdad_pkg::ST_OUT: begin
                if (i_sts.out_free) n_state = cdad_pkg::ST_IDLE;
            end
            default: n_state = cdad_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd           = '0;
        case (r_state)
            cdad_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            cdad_pkg::ST_DIV: begin
                o_cmd.div_step = i_sts.div_busy;
            end
            cdad_pkg::ST_WALK: begin
                o_cmd.walk_step = !i_sts.walk_done;
            end
            cdad_pkg::ST_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/cdad_dp.sv
// datapath: date registers, century/year-in-century split, month walk, result register
// depends on cdad_pkg
`default_nettype none

module cdad_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [cdad_pkg::YEAR_W-1:0]         i_start_year,
    input  wire  [cdad_pkg::MONTH_W-1:0]        i_start_month,
    input  wire  [cdad_pkg::DAY_W-1:0]          i_start_day,
    input  wire  signed [cdad_pkg::OFFS_W-1:0]  i_day_offset,
    input  wire                                 i_m_tready,
    input  cdad_pkg::t_dp_cmd                   i_cmd,
    output cdad_pkg::t_dp_sts                   o_sts,
    output logic                                o_m_tvalid,
    output logic [cdad_pkg::YEAR_W-1:0]         o_result_year,
    output logic [cdad_pkg::MONTH_W-1:0]        o_result_month,
    output logic [cdad_pkg::DAY_W-1:0]          o_result_day,
    output logic                                o_year_overflow
);

    localparam int unsigned ACC_W  = cdad_pkg::ACC_W;
    localparam int unsigned CENT_W = cdad_pkg::CENT_W;

    logic [cdad_pkg::YEAR_W-1:0]  r_year;
    logic [cdad_pkg::YEAR_W-1:0]  r_rem;
    logic [CENT_W-1:0]            r_cent;
    logic [cdad_pkg::MONTH_W-1:0] r_month;
    logic signed [ACC_W-1:0]      r_day;
    logic                         r_ovf;

    logic [cdad_pkg::YEAR_W-1:0]  r_out_year;
    logic [cdad_pkg::MONTH_W-1:0] r_out_month;
    logic [cdad_pkg::DAY_W-1:0]   r_out_day;
    logic                         r_out_ovf;
    logic                         r_out_valid;

    logic [cdad_pkg::YEAR_W-1:0]  year_cl;
    logic [cdad_pkg::MONTH_W-1:0] month_cl;
    logic signed [ACC_W-1:0]      day_init;
    logic [CENT_W-1:0]            yy;
    logic                         leap;
    logic [cdad_pkg::MONTH_W-1:0] prev_month;
    logic [cdad_pkg::DAY_W-1:0]   cur_len;
    logic [cdad_pkg::DAY_W-1:0]   prev_len;
    logic signed [ACC_W-1:0]      cur_len_s;
    logic signed [ACC_W-1:0]      prev_len_s;
    logic                         go_fwd;
    logic                         go_bwd;

    always_comb begin
        if (i_start_year < cdad_pkg::YEAR_MIN) year_cl = cdad_pkg::YEAR_MIN;
        else if (i_start_year > cdad_pkg::YEAR_MAX) year_cl = cdad_pkg::YEAR_MAX;
        else year_cl = i_start_year;

        if (i_start_month < cdad_pkg::MONTH_JAN) month_cl = cdad_pkg::MONTH_JAN;
        else if (i_start_month > cdad_pkg::MONTH_DEC) month_cl = cdad_pkg::MONTH_DEC;
        else month_cl = i_start_month;

        day_init = $signed({{(ACC_W-cdad_pkg::DAY_W){1'b0}}, i_start_day})
                 + $signed({{(ACC_W-cdad_pkg::OFFS_W){i_day_offset[cdad_pkg::OFFS_W-1]}},
                            i_day_offset});
    end

    // leap test on the split year: yy is the year within its century
    always_comb begin
        yy         = r_rem[CENT_W-1:0];
        leap       = (yy[1:0] == 2'd0 && yy != '0) || (yy == '0 && r_cent[1:0] == 2'd0);
        prev_month = (r_month == cdad_pkg::MONTH_JAN) ? cdad_pkg::MONTH_DEC
                                                      : r_month - 4'd1;
        cur_len    = cdad_pkg::month_len(r_month, leap);
        prev_len   = cdad_pkg::month_len(prev_month, leap);
        cur_len_s  = $signed({{(ACC_W-cdad_pkg::DAY_W){1'b0}}, cur_len});
        prev_len_s = $signed({{(ACC_W-cdad_pkg::DAY_W){1'b0}}, prev_len});
        go_fwd     = r_day > cur_len_s;
        go_bwd     = r_day[ACC_W-1] || (r_day == '0);
    end

    always_comb begin
        o_sts.div_busy  = r_rem >= cdad_pkg::YEARS_CENT;
        o_sts.walk_done = r_ovf || (!go_fwd && !go_bwd);
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            r_year  <= year_cl;
            r_rem   <= year_cl;
            r_cent  <= '0;
            r_month <= month_cl;
            r_day   <= day_init;
            r_ovf   <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem  <= r_rem - cdad_pkg::YEARS_CENT;
            r_cent <= r_cent + 7'd1;
        end else if (i_cmd.walk_step) begin
            if (go_fwd) begin
                if (r_month == cdad_pkg::MONTH_DEC) begin
                    if (r_year == cdad_pkg::YEAR_MAX) begin
                        r_month <= cdad_pkg::MONTH_DEC;
                        r_day   <= $signed({{(ACC_W-cdad_pkg::DAY_W){1'b0}},
                                            cdad_pkg::DAY_LAST});
                        r_ovf   <= 1'b1;
                    end else begin
                        r_day   <= r_day - cur_len_s;
                        r_month <= cdad_pkg::MONTH_JAN;
                        r_year  <= r_year + 14'd1;
                        if (yy == cdad_pkg::YY_LAST) begin
                            r_rem  <= '0;
                            r_cent <= r_cent + 7'd1;
                        end else begin
                            r_rem  <= r_rem + 14'd1;
                        end
                    end
                end else begin
                    r_day   <= r_day - cur_len_s;
                    r_month <= r_month + 4'd1;
                end
            end else if (go_bwd) begin
                if (r_month == cdad_pkg::MONTH_JAN) begin
                    if (r_year == cdad_pkg::YEAR_MIN) begin
                        r_day <= $signed({{(ACC_W-cdad_pkg::DAY_W){1'b0}},
                                          cdad_pkg::DAY_FIRST});
                        r_ovf <= 1'b1;
                    end else begin
                        // december needs no leap test
                        r_day   <= r_day + prev_len_s;
                        r_month <= cdad_pkg::MONTH_DEC;
                        r_year  <= r_year - 14'd1;
                        if (yy == '0) begin
                            r_rem  <= {{(cdad_pkg::YEAR_W-CENT_W){1'b0}}, cdad_pkg::YY_LAST};
                            r_cent <= r_cent - 7'd1;
                        end else begin
                            r_rem  <= r_rem - 14'd1;
                        end
                    end
                end else begin
                    r_day   <= r_day + prev_len_s;
                    r_month <= prev_month;
                end
            end
        end
    end

    // result register, frees the walk for the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_year  <= r_year;
            r_out_month <= r_month;
            r_out_day   <= r_day[cdad_pkg::DAY_W-1:0];
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_result_year   = r_out_year;
    assign o_result_month  = r_out_month;
    assign o_result_day    = r_out_day;
    assign o_year_overflow = r_out_ovf;

endmodule

`default_nettype wire

FILE: dv/tb_calendar_date_add_days_core.sv
// self-checking testbench for calendar_date_add_days_core: directed and random dates with
// signed day offsets, checked against a date-walk predictor; depends on cdad_pkg and the core
`timescale 1ns / 100ps

module tb_calendar_date_add_days_core;

    localparam int FIRST_YEAR   = cdad_pkg::YEAR_MIN;
    localparam int LAST_YEAR    = cdad_pkg::YEAR_MAX;
    localparam int FIRST_MONTH  = cdad_pkg::MONTH_JAN;
    localparam int LAST_MONTH   = cdad_pkg::MONTH_DEC;
    localparam int FIRST_DAY    = cdad_pkg::DAY_FIRST;
    localparam int LAST_DAY     = cdad_pkg::DAY_LAST;
    localparam int ITEM_CYCLES  = 1300;
    localparam int RANDOM_BULK  = 460;
    localparam int RANDOM_CALM  = 40;
    localparam int HOLD_AT      = 70;
    localparam int LONG_HOLD    = 4000;

    // packed with year in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [cdad_pkg::OFFS_W-1:0]  offset;
        logic [cdad_pkg::DAY_W-1:0]   day;
        logic [cdad_pkg::MONTH_W-1:0] month;
        logic [cdad_pkg::YEAR_W-1:0]  year;
    } t_date_req;

    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0]  year;
        logic [cdad_pkg::MONTH_W-1:0] month;
        logic [cdad_pkg::DAY_W-1:0]   day;
        logic                         overflow;
    } t_date_res;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [23:0] m_data;
    wire  [0:0]  m_user;

    t_date_req date_requests[$];
    t_date_res expected_dates[$];
    int        sent_cnt = 0;
    int        accepted_cnt = 0;
    int        fail_cnt = 0;
    int        idle_left = 0;
    int        stall_left = 0;
    int        hold_left = 0;
    logic      long_hold_done = 1'b0;
    logic      quiet = 1'b0;

    calendar_date_add_days_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int days_in_month(input int y, input int m);
        logic leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // clamp the start year and month, add the offset to the day, then walk month by month
    function automatic t_date_res shift_date(input t_date_req req);
        int        y;
        int        m;
        int        d;
        logic      ovf;
        t_date_res res;
        y   = req.year;
        m   = req.month;
        d   = req.day;
        ovf = 1'b0;
        if (y < FIRST_YEAR) y = FIRST_YEAR;
        if (y > LAST_YEAR) y = LAST_YEAR;
        if (m < FIRST_MONTH) m = FIRST_MONTH;
        if (m > LAST_MONTH) m = LAST_MONTH;
        d = d + $signed(req.offset);
        while (!ovf && d > days_in_month(y, m)) begin
            d = d - days_in_month(y, m);
            m = m + 1;
            if (m > LAST_MONTH) begin
                m = FIRST_MONTH;
                y = y + 1;
                if (y > LAST_YEAR) begin
                    y   = LAST_YEAR;
                    m   = LAST_MONTH;
                    d   = LAST_DAY;
                    ovf = 1'b1;
                end
            end
        end
        // borrow repeatedly until the day is positive
        while (!ovf && d <= 0) begin
            m = m - 1;
            if (m < FIRST_MONTH) begin
                m = LAST_MONTH;
                y = y - 1;
                if (y < FIRST_YEAR) begin
                    y   = FIRST_YEAR;
                    m   = FIRST_MONTH;
                    d   = FIRST_DAY;
                    ovf = 1'b1;
                end
            end
            if (!ovf) d = d + days_in_month(y, m);
        end
        res.year     = y[cdad_pkg::YEAR_W-1:0];
        res.month    = m[cdad_pkg::MONTH_W-1:0];
        res.day      = d[cdad_pkg::DAY_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    task automatic queue_date(input int y, input int m, input int d, input int off);
        t_date_req req;
        req.year   = y[cdad_pkg::YEAR_W-1:0];
        req.month  = m[cdad_pkg::MONTH_W-1:0];
        req.day    = d[cdad_pkg::DAY_W-1:0];
        req.offset = off[cdad_pkg::OFFS_W-1:0];
        date_requests.push_back(req);
    endtask

    task automatic queue_random_date();
        int kind;
        int y;
        int m;
        int d;
        int off;
        kind = $urandom_range(0, 99);
        y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
        m    = $urandom_range(FIRST_MONTH, LAST_MONTH);
        d    = $urandom_range(FIRST_DAY, days_in_month(y, m));
        off  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 800) - 400
                                           : int'($urandom_range(0, 65535)) - 32768;
        if (kind < 60) begin
            queue_date(y, m, d, off);
        end else if (kind < 65) begin
            // runs toward the top of the year range
            queue_date($urandom_range(9900, LAST_YEAR), m, $urandom_range(1, 28),
                       $urandom_range(0, 32767));
        end else if (kind < 70) begin
            queue_date($urandom_range(FIRST_YEAR, 90), m, $urandom_range(1, 28),
                       -int'($urandom_range(0, 32768)));
        end else if (kind < 80) begin
            // february around century and leap years
            y = 100 * $urandom_range(1, 99) + $urandom_range(0, 4);
            off = ($urandom_range(0, 3) == 0) ? 366 - 732 * $urandom_range(0, 1)
                                              : $urandom_range(0, 6) - 3;
            queue_date(y, 2, $urandom_range(27, 29), off);
        end else begin
            // raw field bits, out-of-range values included
            queue_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                       $urandom_range(0, 65535));
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // sender: holds tvalid until the transfer, otherwise idles in bursts or takes the next item
    always @(negedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && accepted_cnt != sent_cnt) begin
            s_valid <= 1'b1;
        end else if (idle_left > 0) begin
            s_valid   <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid   <= 1'b0;
            idle_left <= $urandom_range(0, 4);
        end else if (date_requests.size() > 0) begin
            s_data   <= {1'b0, date_requests.pop_front()};
            s_valid  <= 1'b1;
            sent_cnt <= sent_cnt + 1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off so the core backs up to its input
    always @(negedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && accepted_cnt == HOLD_AT) begin
            m_ready        <= 1'b0;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : monitor
        t_date_res want;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result transfer: data %h user %h", m_data, m_user);
                    fail_cnt++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("result_year", want.year, m_data[13:0]);
                    check_field("result_month", want.month, m_data[17:14]);
                    check_field("result_day", want.day, m_data[22:18]);
                    check_field("year_overflow", want.overflow, m_user[0]);
                end
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(shift_date(t_date_req'(s_data[38:0])));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_date(1, 1, 1, 0);
        queue_date(1, 1, 1, -1);
        queue_date(1, 1, 1, -32768);
        queue_date(1, 3, 1, -60);
        queue_date(9999, 12, 31, 1);
        queue_date(9999, 12, 31, 32767);
        queue_date(9999, 12, 1, 30);
        queue_date(9999, 12, 1, 31);
        queue_date(2000, 2, 28, 1);
        queue_date(1900, 2, 28, 1);
        queue_date(2000, 3, 1, -1);
        queue_date(2024, 2, 29, 365);
        queue_date(2023, 12, 31, 1);
        queue_date(2024, 1, 1, -1);
        queue_date(0, 6, 15, 0);
        queue_date(16383, 6, 15, -100);
        queue_date(2020, 0, 10, 5);
        queue_date(2020, 15, 10, 5);
        queue_date(2021, 3, 0, 0);
        queue_date(2021, 4, 31, 0);
        queue_date(5000, 7, 4, 32767);
        queue_date(5000, 7, 4, -32768);
        queue_date(16383, 15, 31, 32767);
        queue_date(0, 0, 0, 0);

        // wait until the core has drained
        while (date_requests.size() != 0 || accepted_cnt != sent_cnt ||
               expected_dates.size() != 0)
            @(negedge clk);

        repeat (RANDOM_BULK) queue_random_date();
        while (date_requests.size() != 0) @(negedge clk);
        quiet <= 1'b1;
        repeat (RANDOM_CALM) queue_random_date();

        while (date_requests.size() != 0 || accepted_cnt != sent_cnt ||
               expected_dates.size() != 0)
            @(negedge clk);
        repeat (ITEM_CYCLES) @(negedge clk);

        if (fail_cnt == 0 && expected_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/cdad_pkg.sv
hdl/cdad_ctrl.sv
hdl/cdad_dp.sv
hdl/calendar_date_add_days_core.sv
dv/tb_calendar_date_add_days_core.sv
